// ===== src/timed_actuator_command_scheduler_unit_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef TIMED_ACTUATOR_COMMAND_SCHEDULER_UNIT_DEFINES_SVH
`define TIMED_ACTUATOR_COMMAND_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TACS_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TACS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tacs_pkg.sv =====
`default_nettype none

package tacs_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] actuator_index;
    logic [7:0] drive_speed;
    logic [7:0] run_duration;
    logic [7:0] start_offset;
  } in_t;

  typedef struct packed {
    logic [3:0] drive_actuator;
    logic [7:0] drive_value;
    logic       last_event;
  } out_t;

  // One command slot as kept in the slot memory.
  typedef struct packed {
    logic [7:0]  speed;
    logic [31:0] start_time;
    logic [31:0] stop_time;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam int         MAX_EVENTS = 50;
  localparam int         CNT_W      = 6;
  localparam logic [7:0] STOP_VALUE = 8'd0;

endpackage

`default_nettype wire

// ===== src/timed_actuator_command_scheduler_unit.sv =====
// Timed actuator command scheduler.
// Input channel (in_valid/in_stall/in_data) takes two kinds of beats. A command
// beat stores a timed command in the ring of its actuator; actuator indices at
// or above NUM_ACTUATORS are dropped. A command runs through ST_CMD_A and
// ST_CMD_B (two chained 32-bit adds), then ST_CMD_C (the slot memory write).
// A tick beat advances the millisecond counter and sweeps all queues in order.
// The sweep visits each queue in ST_QHEAD, each slot of an active queue in
// ST_SLOT_RD and each valid slot once more in ST_SLOT_EV, then ends in
// ST_FINISH; idle queues and empty slots make it shorter. The slot memory
// has one read port, so the slots are read one by one.
// Output channel (out_valid/out_stall/out_data) carries one beat per start or
// stop event, up to MAX_EVENTS per sweep; last_event marks the final beat of a
// sweep. One event is held back so that the last one can be tagged, so beats
// appear from the second event on and the last one when the sweep ends. A tick
// giving no event gives no beat. A stalled receiver pauses the sweep at its
// next event. The block takes a new beat once the sweep is done, even while
// the final result still waits in the output register.
// Reset clears the time, all slot valid bits and the queue state; the slot
// memory contents need no clearing.
`default_nettype none

module timed_actuator_command_scheduler_unit #(
  parameter int NUM_ACTUATORS = 10,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tacs_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tacs_pkg::out_t     out_data
);

  import tacs_pkg::*;

  `include "timed_actuator_command_scheduler_unit_defines.svh"

  localparam int NUM_SLOTS = NUM_ACTUATORS * QUEUE_DEPTH;
  localparam int QW = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [QW-1:0]    LAST_Q    = QW'(NUM_ACTUATORS - 1);
  localparam logic [PW-1:0]    LAST_P    = PW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0]    DEPTH_A   = AW'(QUEUE_DEPTH);
  localparam logic [7:0]       ACT_LIMIT = 8'(NUM_ACTUATORS);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_EVENTS);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_CMD_A   = 8'b0000_0010,
    ST_CMD_B   = 8'b0000_0100,
    ST_CMD_C   = 8'b0000_1000,
    ST_QHEAD   = 8'b0001_0000,
    ST_SLOT_RD = 8'b0010_0000,
    ST_SLOT_EV = 8'b0100_0000,
    ST_FINISH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]      time_r;
  logic [QW-1:0]    q_idx_r;
  logic [PW-1:0]    p_idx_r;
  logic [CNT_W-1:0] cnt_r;

  logic             slot_valid_r   [NUM_SLOTS];
  logic             slot_started_r [NUM_SLOTS];
  logic [PW-1:0]    q_ptr_r        [NUM_ACTUATORS];
  logic [31:0]      q_latest_r     [NUM_ACTUATORS];
  logic             q_active_r     [NUM_ACTUATORS];
  logic [31:0]      q_cur_r        [NUM_ACTUATORS];

  logic [QW-1:0]    cmd_act_r;
  logic [7:0]       cmd_speed_r;
  logic [7:0]       cmd_dur_r;
  logic [7:0]       cmd_off_r;
  logic [PW-1:0]    cmd_ptr_r;
  logic [31:0]      start_r;
  logic [31:0]      stop_r;

  logic             hold_v_r;
  out_t             hold_r;
  logic             out_v_r;
  out_t             out_r;

  logic             in_acc;
  logic             out_free;
  logic             can_push;
  logic             emit_room;
  logic [AW-1:0]    slot_addr;
  logic [AW-1:0]    cmd_addr;
  slot_t            rd_slot;
  slot_t            wr_slot;
  logic [SLOT_BITS-1:0] rd_bits;

  logic             tick_go, cmd_go, rd_en, push, flush;
  logic             p_clear, p_step, q_step;
  logic             head_off, clr_slot, set_started;
  logic [7:0]       push_val;

  logic             due, stale, started, expired, ev_emit, ev_clear, ev_start;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign out_free  = !out_v_r || !out_stall;
  assign can_push  = !hold_v_r || out_free;
  assign emit_room = (cnt_r < CNT_MAX);

  assign slot_addr = AW'(AW'(q_idx_r) * DEPTH_A) + AW'(p_idx_r);
  assign cmd_addr  = AW'(AW'(cmd_act_r) * DEPTH_A) + AW'(cmd_ptr_r);

  assign wr_slot.speed      = cmd_speed_r;
  assign wr_slot.start_time = start_r;
  assign wr_slot.stop_time  = stop_r;
  assign rd_slot            = slot_t'(rd_bits);

  tacs_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (state_r == ST_CMD_C),
    .wr_addr (cmd_addr),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (slot_addr),
    .rd_data (rd_bits)
  );

  // Slot decision for the entry whose data has just come out of the memory.
  always_comb begin
    due      = !(rd_slot.start_time > time_r);
    stale    = rd_slot.start_time < q_cur_r[q_idx_r];
    started  = slot_started_r[slot_addr];
    expired  = rd_slot.stop_time <= time_r;
    ev_emit  = 1'b0;
    ev_clear = 1'b0;
    ev_start = 1'b0;
    if (due) begin
      if (stale) begin
        ev_clear = 1'b1;
      end else if (started) begin
        ev_clear = (rd_slot.start_time != q_cur_r[q_idx_r]) || expired;
        ev_emit  = expired;
      end else if (expired) begin
        ev_clear = 1'b1;
      end else begin
        ev_emit  = 1'b1;
        ev_start = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    tick_go     = 1'b0;
    cmd_go      = 1'b0;
    rd_en       = 1'b0;
    push        = 1'b0;
    flush       = 1'b0;
    p_clear     = 1'b0;
    p_step      = 1'b0;
    q_step      = 1'b0;
    head_off    = 1'b0;
    clr_slot    = 1'b0;
    set_started = 1'b0;
    push_val    = STOP_VALUE;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == REQ_TICK) begin
            tick_go   = 1'b1;
            state_nxt = ST_QHEAD;
          end else if (in_data.actuator_index < ACT_LIMIT) begin
            cmd_go    = 1'b1;
            state_nxt = ST_CMD_A;
          end
        end
      end
      ST_CMD_A: state_nxt = ST_CMD_B;
      ST_CMD_B: state_nxt = ST_CMD_C;
      ST_CMD_C: state_nxt = ST_IDLE;
      ST_QHEAD: begin
        if (!q_active_r[q_idx_r]) begin
          if (q_idx_r == LAST_Q) begin
            state_nxt = ST_FINISH;
          end else begin
            q_step = 1'b1;
          end
        end else if (q_latest_r[q_idx_r] <= time_r) begin
          // Safeguard stop once the queue's latest stop time has been reached.
          if (!emit_room || can_push) begin
            head_off  = 1'b1;
            push      = emit_room;
            p_clear   = 1'b1;
            state_nxt = ST_SLOT_RD;
          end
        end else begin
          p_clear   = 1'b1;
          state_nxt = ST_SLOT_RD;
        end
      end
      ST_SLOT_RD: begin
        if (slot_valid_r[slot_addr]) begin
          rd_en     = 1'b1;
          state_nxt = ST_SLOT_EV;
        end else if (p_idx_r != LAST_P) begin
          p_step = 1'b1;
        end else if (q_idx_r == LAST_Q) begin
          state_nxt = ST_FINISH;
        end else begin
          q_step    = 1'b1;
          state_nxt = ST_QHEAD;
        end
      end
      ST_SLOT_EV: begin
        if (!(ev_emit && emit_room && !can_push)) begin
          clr_slot    = ev_clear;
          set_started = ev_start;
          push        = ev_emit && emit_room;
          push_val    = ev_start ? rd_slot.speed : STOP_VALUE;
          if (p_idx_r != LAST_P) begin
            p_step    = 1'b1;
            state_nxt = ST_SLOT_RD;
          end else if (q_idx_r == LAST_Q) begin
            state_nxt = ST_FINISH;
          end else begin
            q_step    = 1'b1;
            state_nxt = ST_QHEAD;
          end
        end
      end
      ST_FINISH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          flush     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      time_r   <= '0;
      q_idx_r  <= '0;
      p_idx_r  <= '0;
      cnt_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_valid_r[s]   <= 1'b0;
        slot_started_r[s] <= 1'b0;
      end
      for (int q = 0; q < NUM_ACTUATORS; q++) begin
        q_ptr_r[q]    <= '0;
        q_latest_r[q] <= '0;
        q_active_r[q] <= 1'b0;
        q_cur_r[q]    <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (tick_go) begin
        time_r  <= time_r + 32'd1;
        q_idx_r <= '0;
        cnt_r   <= '0;
      end
      if (q_step) begin
        q_idx_r <= q_idx_r + QW'(1);
      end
      if (p_clear) begin
        p_idx_r <= '0;
      end else if (p_step) begin
        p_idx_r <= p_idx_r + PW'(1);
      end

      if (cmd_go) begin
        cmd_act_r   <= in_data.actuator_index[QW-1:0];
        cmd_speed_r <= in_data.drive_speed;
        cmd_dur_r   <= in_data.run_duration;
        cmd_off_r   <= in_data.start_offset;
      end
      if (state_r == ST_CMD_A) begin
        start_r   <= time_r + 32'(cmd_off_r);
        cmd_ptr_r <= (q_ptr_r[cmd_act_r] == LAST_P) ? '0 : q_ptr_r[cmd_act_r] + PW'(1);
      end
      if (state_r == ST_CMD_B) begin
        stop_r <= start_r + 32'(cmd_dur_r);
      end
      if (state_r == ST_CMD_C) begin
        slot_valid_r[cmd_addr]   <= 1'b1;
        slot_started_r[cmd_addr] <= 1'b0;
        q_ptr_r[cmd_act_r]       <= cmd_ptr_r;
        q_active_r[cmd_act_r]    <= 1'b1;
        if (stop_r > q_latest_r[cmd_act_r]) begin
          q_latest_r[cmd_act_r] <= stop_r;
        end
      end

      if (head_off) begin
        q_active_r[q_idx_r] <= 1'b0;
      end
      if (clr_slot) begin
        slot_valid_r[slot_addr] <= 1'b0;
      end
      if (set_started) begin
        slot_started_r[slot_addr] <= 1'b1;
        q_cur_r[q_idx_r]          <= rd_slot.start_time;
      end

      // One event waits in the hold register so the final one can be tagged.
      if (push) begin
        cnt_r                 <= cnt_r + CNT_W'(1);
        hold_v_r              <= 1'b1;
        hold_r.drive_actuator <= 4'(q_idx_r);
        hold_r.drive_value    <= push_val;
        hold_r.last_event     <= 1'b0;
        if (hold_v_r) begin
          out_r   <= hold_r;
          out_v_r <= 1'b1;
        end else if (out_v_r && !out_stall) begin
          out_v_r <= 1'b0;
        end
      end else if (flush) begin
        out_r    <= '{drive_actuator: hold_r.drive_actuator,
                      drive_value:    hold_r.drive_value,
                      last_event:     1'b1};
        out_v_r  <= 1'b1;
        hold_v_r <= 1'b0;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  `TACS_ASSERT_IMPLY(a_idle_hold_empty, clk, rst_n, state_r == ST_IDLE, !hold_v_r, "event left in hold register after sweep")
  `TACS_ASSERT_IMPLY(a_eval_valid_slot, clk, rst_n, state_r == ST_SLOT_EV, slot_valid_r[slot_addr], "evaluating an empty slot")
  `TACS_ASSERT_NEXT(a_tick_starts_sweep, clk, rst_n, in_acc && in_data.req_type == REQ_TICK, state_r == ST_QHEAD, "tick beat did not start a sweep")
  `TACS_ASSERT_IMPLY(a_hold_counted, clk, rst_n, hold_v_r, cnt_r != '0 && cnt_r <= CNT_MAX, "event count out of step with hold register")

endmodule

`default_nettype wire

// ===== src/tacs_ram.sv =====
`default_nettype none

module tacs_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 40
) (
  input  wire logic                                         clk,
  input  wire logic                                         wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                             wr_data,
  input  wire logic                                         rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
